@@ rtl/pmmv_pkg.sv @@
`timescale 1ns / 1ps
// Types, constants and the step program shared by the marimba voice modules.
package pmmv_pkg;

  // Operand selections for the shared multiplier.
  typedef enum logic [4:0] {
    M_NONE, M_W1, M_WA, M_SQ, M_S1, M_S2, M_S3, M_SW, M_MK, M_E0,
    M_NT1, M_NT2, M_RT, M_X0, M_X1, M_X2, M_ENV, M_ATT, M_OUT, M_PH
  } mul_t;

  // Write-back of the previous product.
  typedef enum logic [3:0] {
    WB_NONE, WB_Y, WB_Y16, WB_EX, WB_W1, WB_WA, WB_MACC, WB_MK, WB_S,
    WB_E0, WB_ENV, WB_ENVR, WB_PH
  } wb_t;

  // Which harmonic feeds the sine evaluation and its weight.
  typedef enum logic [2:0] {H_1, H_2, H_3, H_5, H_OUT} harm_t;

  typedef enum logic [0:0] {CFG_PHASE_STEP = 1'b0, CFG_VELOCITY = 1'b1} cfg_idx_t;

  typedef enum logic {CS_IDLE, CS_RUN} ctl_state_t;

  typedef struct packed {
    logic  load;
    logic  div_start;
    logic  out_load;
    wb_t   wb;
    mul_t  mul;
    harm_t harm;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  localparam int unsigned STEP_BITS = 6;
  localparam logic [STEP_BITS-1:0] STEP_ATT  = 6'd44;
  localparam logic [STEP_BITS-1:0] STEP_LAST = 6'd54;
  localparam logic [4:0] DIV_STEPS = 5'd17;

  // Fixed-point constants.
  localparam logic [15:0] K_W_01   = 16'd6554;
  localparam logic [15:0] K_W_03   = 16'd19661;
  localparam logic [15:0] K_W_08   = 16'd52429;
  localparam logic [15:0] K_RAD    = 16'd10430;
  localparam logic [15:0] K_AMP    = 16'd26214;
  localparam logic [15:0] K_SLOW   = 16'd1891;
  localparam logic [15:0] K_ATT    = 16'd577;
  localparam logic [19:0] K_REL    = 20'd945481;
  localparam logic [15:0] K_SIN_A  = 16'd51459;
  localparam logic [15:0] K_SIN_B  = 16'd21060;
  localparam logic [15:0] K_SIN_C  = 16'd2369;
  localparam logic [15:0] K_EXP_A  = 16'd45347;
  localparam logic [15:0] K_EXP_B  = 16'd15372;
  localparam logic [15:0] K_EXP_C  = 16'd2793;

  // Step program: a step may write back the last product, start the next, or both.
  function automatic cmd_t prog_cmd(input logic [STEP_BITS-1:0] step);
    cmd_t c;
    c           = '0;
    c.wb        = WB_NONE;
    c.mul       = M_NONE;
    c.harm      = H_1;
    unique case (step) inside
      6'd0:                          c.mul = M_NT2;
      6'd1:                          c.wb  = WB_Y;
      6'd2, 6'd38, 6'd47:            c.mul = M_X0;
      6'd3, 6'd39, 6'd48:            c.mul = M_X1;
      6'd4, 6'd40, 6'd49:            c.mul = M_X2;
      6'd5, 6'd41, 6'd50:            c.wb  = WB_EX;
      6'd6: begin
        c.mul       = M_W1;
        c.div_start = 1'b1;
      end
      6'd7: begin
        c.wb  = WB_W1;
        c.mul = M_WA;
      end
      6'd8: begin
        c.wb   = WB_WA;
        c.mul  = M_SQ;
        c.harm = H_5;
      end
      6'd9, 6'd14, 6'd19, 6'd24, 6'd32:  c.mul = M_S1;
      6'd10, 6'd15, 6'd20, 6'd25, 6'd33: c.mul = M_S2;
      6'd11, 6'd16, 6'd21, 6'd26, 6'd34: c.mul = M_S3;
      6'd12: begin
        c.mul  = M_SW;
        c.harm = H_5;
      end
      6'd13: begin
        c.wb   = WB_MACC;
        c.mul  = M_SQ;
        c.harm = H_1;
      end
      6'd17: begin
        c.mul  = M_SW;
        c.harm = H_1;
      end
      6'd18: begin
        c.wb   = WB_MACC;
        c.mul  = M_SQ;
        c.harm = H_3;
      end
      6'd22: begin
        c.mul  = M_SW;
        c.harm = H_3;
      end
      6'd23: begin
        c.wb   = WB_MACC;
        c.mul  = M_SQ;
        c.harm = H_2;
      end
      6'd27: begin
        c.mul  = M_SW;
        c.harm = H_2;
      end
      6'd28:                         c.wb  = WB_MACC;
      6'd29:                         c.mul = M_MK;
      6'd30:                         c.wb  = WB_MK;
      6'd31: begin
        c.mul  = M_SQ;
        c.harm = H_OUT;
      end
      6'd35: begin
        c.wb  = WB_S;
        c.mul = M_E0;
      end
      6'd36: begin
        c.wb  = WB_E0;
        c.mul = M_NT1;
      end
      6'd37, 6'd46:                  c.wb  = WB_Y16;
      6'd42, 6'd51:                  c.mul = M_ENV;
      6'd43:                         c.wb  = WB_ENV;
      6'd44:                         c.mul = M_ATT;
      6'd45: begin
        c.wb  = WB_ENV;
        c.mul = M_RT;
      end
      6'd52: begin
        c.wb  = WB_ENVR;
        c.mul = M_PH;
      end
      6'd53: begin
        c.wb  = WB_PH;
        c.mul = M_OUT;
      end
      default: ;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/pmmv_div.sv @@
`timescale 1ns / 1ps
// Restoring divider for the attack curve, one quotient bit per cycle.
module pmmv_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] ex,
  output logic [16:0] quo,
  output logic        done
);
  import pmmv_pkg::*;

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [17:0] rem_r;
  logic [16:0] num_r;
  logic [16:0] quo_r;
  logic [17:0] den_r;
  logic [32:0] num_nxt;
  logic [18:0] trial;
  logic        fits;

  // Numerator is (1 - e) in Q16 shifted up by 16; the quotient never exceeds 2^16.
  assign num_nxt = {17'(17'd65536 - ex), 16'd0};
  assign trial   = {rem_r, num_r[16]};
  assign fits    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_STEPS;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {2'b00, num_nxt[32:17]};
      num_r <= num_nxt[16:0];
      den_r <= 18'(18'd65536 + 18'(ex));
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? 18'(trial - {1'b0, den_r}) : trial[17:0];
      num_r <= {num_r[15:0], 1'b0};
      quo_r <= {quo_r[15:0], fits};
    end
  end

  assign quo  = quo_r;
  assign done = !busy_r;

endmodule

@@ rtl/pmmv_dp.sv @@
`timescale 1ns / 1ps
// Datapath: phase accumulator, shared multiplier, sine, envelope and output register.
module pmmv_dp #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pmmv_pkg::cmd_t       cmd,
  output pmmv_pkg::sts_t       sts,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [30:0]          cfg_data,
  input  logic [15:0]          in_rate,
  input  logic [23:0]          in_note_time,
  input  logic                 in_released,
  input  logic [23:0]          in_release_time,
  input  logic [15:0]          in_knob_a,
  input  logic [15:0]          in_knob_b,
  output logic signed [15:0]   sample
);
  import pmmv_pkg::*;

  localparam logic [31:0] QMASK = ~((32'h1 << (32 - SINE_TABLE_BITS)) - 32'h1);
  localparam int unsigned SHR   = 62 - PHASE_BITS;

  logic [PHASE_BITS-1:0] acc_r;
  logic [30:0]           ps_r;
  logic [15:0]           vel_r;
  logic [15:0]           rate_r;
  logic [23:0]           nt_r;
  logic                  rel_r;
  logic [23:0]           rt_r;
  logic [15:0]           ka_r;
  logic [15:0]           kb_r;
  logic [31:0]           p_r;
  logic signed [52:0]    prod_r;
  logic [15:0]           sx_r;
  logic                  sneg_r;
  logic [15:0]           x2_r;
  logic [15:0]           w1_r;
  logic [15:0]           wa_r;
  logic signed [19:0]    m_r;
  logic [31:0]           mk_r;
  logic signed [15:0]    s_r;
  logic [33:0]           y_r;
  logic [16:0]           ex_r;
  logic [16:0]           env_r;
  logic signed [15:0]    sample_r;

  logic [31:0]           p_nxt;
  logic [31:0]           ang;
  logic [31:0]           sin_q;
  logic [15:0]           x0;
  logic [15:0]           sin_x;
  logic [16:0]           p15;
  logic [16:0]           p16;
  logic [14:0]           rc;
  logic signed [15:0]    s_now;
  logic [15:0]           wgt;
  logic signed [31:0]    mul_a;
  logic signed [20:0]    mul_b;
  logic signed [52:0]    prod_nxt;
  logic [17:0]           en;
  logic [16:0]           pm;
  logic [16:0]           ex_nxt;
  logic [62:0]           wide;
  logic [PHASE_BITS-1:0] adv;
  logic signed [36:0]    sh16;
  logic signed [15:0]    sat;
  logic [16:0]           quo;
  logic                  div_done;

  pmmv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .ex    (ex_r),
    .quo   (quo),
    .done  (div_done)
  );

  assign sts.div_done = div_done;

  // Base phase as a 32-bit turn fraction.
  generate
    if (PHASE_BITS >= 32) begin : g_p_wide
      assign p_nxt = acc_r[PHASE_BITS-1 -: 32];
    end else begin : g_p_narrow
      assign p_nxt = {acc_r, {(32 - PHASE_BITS){1'b0}}};
    end
  endgenerate

  always_comb begin
    case (cmd.harm)
      H_1:     ang = p_r;
      H_2:     ang = {p_r[30:0], 1'b0};
      H_3:     ang = p_r + {p_r[30:0], 1'b0};
      H_5:     ang = p_r + {p_r[29:0], 2'b00};
      H_OUT:   ang = p_r + mk_r;
      default: ang = p_r;
    endcase
  end

  assign sin_q = ang & QMASK;
  assign x0    = {1'b0, sin_q[29:15]};
  assign sin_x = sin_q[30] ? 16'(17'd32768 - 17'(x0)) : x0;

  assign p15   = prod_r[31:15];
  assign p16   = prod_r[32:16];
  assign rc    = (p15 > 17'd32767) ? 15'h7FFF : p15[14:0];
  assign s_now = sneg_r ? -$signed({1'b0, rc}) : $signed({1'b0, rc});

  always_comb begin
    case (cmd.harm)
      H_5:     wgt = w1_r;
      H_1:     wgt = K_W_01;
      H_3:     wgt = wa_r;
      H_2:     wgt = kb_r;
      default: wgt = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      M_W1:  begin mul_a = 32'(K_W_03);                     mul_b = 21'(vel_r);      end
      M_WA:  begin mul_a = 32'(K_W_08);                     mul_b = 21'(ka_r);       end
      M_SQ:  begin mul_a = 32'(sin_x);                      mul_b = 21'(sin_x);      end
      M_S1:  begin mul_a = 32'(K_SIN_C);                    mul_b = 21'(p15);        end
      M_S2:  begin mul_a = 32'(16'(K_SIN_B - p15[15:0]));   mul_b = 21'(x2_r);       end
      M_S3:  begin mul_a = 32'(16'(K_SIN_A - p15[15:0]));   mul_b = 21'(sx_r);       end
      M_SW:  begin mul_a = 32'(s_now);                      mul_b = 21'(wgt);        end
      M_MK:  begin mul_a = 32'(m_r);                        mul_b = 21'(K_RAD);      end
      M_E0:  begin mul_a = 32'(K_AMP);                      mul_b = 21'(vel_r);      end
      M_NT1: begin mul_a = 32'(nt_r);                       mul_b = 21'(K_SLOW);     end
      M_NT2: begin mul_a = 32'(nt_r);                       mul_b = 21'(K_ATT);      end
      M_RT:  begin mul_a = 32'(rt_r);                       mul_b = 21'(K_REL);      end
      M_X0:  begin mul_a = 32'(K_EXP_C);                    mul_b = 21'(y_r[15:0]);  end
      M_X1:  begin mul_a = 32'(16'(K_EXP_B - p16[15:0]));   mul_b = 21'(y_r[15:0]);  end
      M_X2:  begin mul_a = 32'(16'(K_EXP_A - p16[15:0]));   mul_b = 21'(y_r[15:0]);  end
      M_ENV: begin mul_a = 32'(env_r);                      mul_b = 21'(ex_r);       end
      M_ATT: begin mul_a = 32'(env_r);                      mul_b = 21'(quo);        end
      M_OUT: begin mul_a = 32'(s_r);                        mul_b = 21'(env_r);      end
      M_PH:  begin mul_a = 32'(ps_r);                       mul_b = 21'(rate_r);     end
      default: ;
    endcase
  end

  assign prod_nxt = (cmd.mul == M_NONE) ? prod_r : 53'(mul_a) * 53'(mul_b);

  // 2^-y: polynomial in the fraction, shifted by the integer part.
  assign en     = y_r[33:16];
  assign pm     = 17'(17'd65536 - p16);
  assign ex_nxt = (en > 18'd16) ? 17'd0 : (pm >> en[4:0]);

  assign wide = {prod_r[46:0], 16'd0};
  assign adv  = wide[SHR +: PHASE_BITS];

  assign sh16 = prod_r[52:16];
  assign sat  = (sh16 > 37'sd32767)  ? 16'sh7FFF :
                (sh16 < -37'sd32768) ? 16'sh8000 : sh16[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ps_r  <= '0;
      vel_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PHASE_STEP: ps_r  <= cfg_data;
          CFG_VELOCITY:   vel_r <= cfg_data[15:0];
        endcase
      end
      if (cmd.wb == WB_PH) begin
        acc_r <= acc_r + adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load) begin
      rate_r <= in_rate;
      nt_r   <= in_note_time;
      rel_r  <= in_released;
      rt_r   <= in_release_time;
      ka_r   <= in_knob_a;
      kb_r   <= in_knob_b;
      p_r    <= p_nxt;
    end
    if (cmd.mul == M_SQ) begin
      sx_r   <= sin_x;
      sneg_r <= sin_q[31];
    end
    if (cmd.mul == M_S1) begin
      x2_r <= p15[15:0];
    end
    if (cmd.out_load) begin
      sample_r <= sat;
    end
    case (cmd.wb)
      WB_Y:    y_r   <= prod_r[33:0];
      WB_Y16:  y_r   <= prod_r[49:16];
      WB_EX:   ex_r  <= ex_nxt;
      WB_W1: begin
        w1_r <= 16'(K_W_01 + p16[15:0]);
        m_r  <= '0;
      end
      WB_WA:   wa_r  <= p16[15:0];
      WB_MACC: m_r   <= m_r + 20'(prod_r >>> 15);
      WB_MK:   mk_r  <= prod_r[31:0];
      WB_S:    s_r   <= s_now;
      WB_E0:   env_r <= p16;
      WB_ENV:  env_r <= p16;
      WB_ENVR: begin
        if (rel_r) begin
          env_r <= p16;
        end
      end
      default: ;
    endcase
  end

  assign sample = sample_r;

endmodule

@@ rtl/pmmv_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: request handshake, step sequencer and output valid.
module pmmv_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  pmmv_pkg::sts_t sts,
  output pmmv_pkg::cmd_t cmd
);
  import pmmv_pkg::*;

  ctl_state_t           state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign hold = ((step_r == STEP_ATT) && !sts.div_done) ||
                ((step_r == STEP_LAST) && out_valid_r && out_stall);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = prog_cmd(step_r);
    in_stall  = 1'b1;
    unique case (state_r)
      CS_IDLE: begin
        cmd      = prog_cmd(STEP_LAST);
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = CS_RUN;
          step_nxt  = '0;
        end
      end
      CS_RUN: begin
        if (!hold) begin
          if (step_r == STEP_LAST) begin
            cmd.out_load = 1'b1;
            state_nxt    = CS_IDLE;
          end else begin
            step_nxt = step_r + 6'd1;
          end
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/phase_modulated_marimba_voice_top.sv @@
`timescale 1ns / 1ps
// Top level of the phase-modulated marimba voice.
//
//   Channel  Direction  Handshake             Payload
//   in_      request in in_valid / in_stall   rate, note_time, released, release_time,
//                                             knob_a, knob_b
//   out_     request out out_valid / out_stall sample (signed Q1.15)
//   cfg_     write      cfg_we                cfg_index, cfg_data
//
// Each request passes from acceptance to the next acceptance through the idle
// state and 55 sequencer steps, all paced by the single shared 32 x 21 multiplier.
// The attack divider runs alongside the sine steps and is long finished when needed.
// Reset is synchronous and active low; it clears the phase accumulator, both
// configuration registers and the handshake state.
// A finished sample sits in the output register while the next request is taken;
// only when the following sample is ready and the first still stalls does the
// sequencer wait on its final step.
module phase_modulated_marimba_voice_top #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_rate,
  input  logic [23:0]        in_note_time,
  input  logic               in_released,
  input  logic [23:0]        in_release_time,
  input  logic [15:0]        in_knob_a,
  input  logic [15:0]        in_knob_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_data
);
  import pmmv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller walks the step program and owns both handshakes.
  pmmv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds all arithmetic state, including the output register.
  pmmv_dp #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_rate         (in_rate),
    .in_note_time    (in_note_time),
    .in_released     (in_released),
    .in_release_time (in_release_time),
    .in_knob_a       (in_knob_a),
    .in_knob_b       (in_knob_b),
    .sample          (out_sample)
  );

  // Once a request is taken the block is busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while a previous one is in progress");

  // The attack multiply must not be passed while the divider is still working.
  a_att_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul == M_ATT && !sts.div_done) |=> (cmd.mul == M_ATT))
    else $error("attack step left before the division finished");

  // A new sample never overwrites one still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("output register loaded while its sample is stalled");

  // Starting the divider makes it busy on the following cycle.
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done)
    else $error("divider did not start");

endmodule

@@ tb/sv/phase_modulated_marimba_voice_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the phase-modulated marimba voice.
module phase_modulated_marimba_voice_top_test;
  import pmmv_pkg::*;

  // A stimulus row: one request and, where it is obvious, the sample it must give.
  typedef struct {
    logic [15:0] rate;
    logic [23:0] note_time;
    logic        released;
    logic [23:0] release_time;
    logic [15:0] knob_a;
    logic [15:0] knob_b;
    bit          known;
    logic signed [15:0] sample;
  } voice_req_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_OFF       = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [15:0] in_rate;
  logic [23:0] in_note_time;
  logic in_released;
  logic [23:0] in_release_time;
  logic [15:0] in_knob_a;
  logic [15:0] in_knob_b;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_sample;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [30:0] cfg_data;

  phase_modulated_marimba_voice_top dut (.*);

  // Predictor state: its own copy of the accumulator and of both registers.
  logic [31:0] model_phase;
  logic [30:0] model_step;
  logic [15:0] model_velocity;

  logic signed [15:0] sample_queue[$];
  int  fail_count;
  bit  calm;          // no idling on the sender or the receiver
  bit  hold_request;  // asks the receiver for one long hold-off
  bit  hold_done;

  // Initial clock: 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Quarter-wave polynomial sine of a turn phase, Q15.
  function automatic longint turn_sine(input logic [31:0] u);
    logic [31:0] q;
    longint x, x2, t, r;
    q  = {u[31 -: 10], 22'd0};
    x  = longint'(q[29:15]);
    if (q[30]) x = 32768 - x;
    x2 = (x * x) >>> 15;
    t  = 21060 - ((2369 * x2) >>> 15);
    t  = 51459 - ((t * x2) >>> 15);
    r  = (t * x) >>> 15;
    if (r > 32767) r = 32767;
    return q[31] ? -r : r;
  endfunction

  // 2^-y with y in Q16, result in Q16; zero once the integer part passes 16.
  function automatic longint pow2_neg(input longint y);
    longint n, f, t;
    n = y >>> 16;
    f = y & 64'hFFFF;
    if (n > 16) return 0;
    t = 15372 - ((2793 * f) >>> 16);
    t = 45347 - ((t * f) >>> 16);
    t = (t * f) >>> 16;
    return (65536 - t) >>> n;
  endfunction

  // Works out the sample for one request and advances the accumulator.
  function automatic logic signed [15:0] voice_sample(input voice_req_t r);
    logic [31:0] p, offs;
    longint v, m, s, env, e, att, smp;
    logic [63:0] adv;
    p = model_phase;
    v = longint'(model_velocity);
    m  = (turn_sine(p * 5) * (6554 + ((19661 * v) >>> 16))) >>> 15;
    m += (turn_sine(p) * 6554) >>> 15;
    m += (turn_sine(p * 3) * ((52429 * longint'(r.knob_a)) >>> 16)) >>> 15;
    m += (turn_sine(p * 2) * longint'(r.knob_b)) >>> 15;
    offs = 32'(m * 10430);
    s = turn_sine(p + offs);
    env = (26214 * v) >>> 16;
    env = (env * pow2_neg((longint'(r.note_time) * 1891) >>> 16)) >>> 16;
    e   = pow2_neg(longint'(r.note_time) * 577);
    att = ((65536 - e) <<< 16) / (65536 + e);
    env = (env * att) >>> 16;
    if (r.released)
      env = (env * pow2_neg((longint'(r.release_time) * 945481) >>> 16)) >>> 16;
    smp = (s * env) >>> 16;
    if (smp > 32767) smp = 32767;
    if (smp < -32768) smp = -32768;
    adv = (64'(model_step) * 64'(r.rate)) >> 14;
    model_phase = model_phase + adv[31:0];
    return 16'(smp);
  endfunction

  // Register writes happen only while the block is idle. The enable is
  // high for a single cycle and is lowered after each write.
  task automatic write_reg(input cfg_idx_t idx, input logic [30:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_PHASE_STEP) model_step = value;
    else model_velocity = value[15:0];
    @(posedge clk);
  endtask

  // Offers one request and waits until the block takes it. The valid stays high
  // when the next request follows straight away, so it is never lowered and
  // raised within one time step.
  task automatic send_request(input voice_req_t r);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_rate         <= r.rate;
    in_note_time    <= r.note_time;
    in_released     <= r.released;
    in_release_time <= r.release_time;
    in_knob_a       <= r.knob_a;
    in_knob_b       <= r.knob_b;
    do @(posedge clk); while (in_stall);
    // Accepted at this edge: the predictor runs either way so that the
    // accumulator stays in step, and a typed value takes precedence.
    begin
      logic signed [15:0] predicted;
      predicted = voice_sample(r);
      sample_queue.push_back(r.known ? r.sample : predicted);
    end
  endtask

  // Lets every outstanding sample arrive, then gives the sequencer time to settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (sample_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random request. Most note and release times are short so that the
  // envelope is audible; a share spans the full range to reach the extremes.
  function automatic voice_req_t random_request;
    voice_req_t r;
    r.rate      = 16'($urandom);
    r.knob_a    = 16'($urandom);
    r.knob_b    = 16'($urandom);
    r.released  = 1'($urandom);
    r.note_time = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                              : 24'($urandom_range(0, 20000));
    r.release_time = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                 : 24'($urandom_range(0, 8000));
    r.known  = 1'b0;
    r.sample = '0;
    return r;
  endfunction

  // Receiver: stalls in random bursts, and once holds off for a long stretch
  // so that the block fills up and pushes back on its input. The stall after
  // the long stretch is set by the next burst.
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 1) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Each sample taken is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sample_queue.size() == 0) begin
        $error("unexpected sample %0d with nothing outstanding", out_sample);
        fail_count++;
      end else begin
        logic signed [15:0] want;
        want = sample_queue.pop_front();
        if (out_sample !== want) begin
          $error("sample: expected %0d, actual %0d", want, out_sample);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    voice_req_t table_rows[18];
    logic [30:0] phase_steps[6];
    logic [15:0] velocities[6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rate = '0;
    in_note_time = '0;
    in_released = 1'b0;
    in_release_time = '0;
    in_knob_a = '0;
    in_knob_b = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PHASE_STEP;
    cfg_data = '0;
    fail_count = 0;
    calm = 1'b0;
    hold_request = 1'b0;
    model_phase = '0;
    model_step = '0;
    model_velocity = '0;

    // rate, note_time, released, release_time, knob_a, knob_b, known, sample
    table_rows = '{
      // Straight after reset the velocity is zero, so the voice is silent.
      '{16'hFFFF, 24'd3000, 1'b0, 24'd0, 16'hFFFF, 16'hFFFF, 1'b1, 16'sd0},
      '{16'h4000, 24'd700, 1'b1, 24'd10, 16'h0000, 16'h0000, 1'b1, 16'sd0},
      // From here on velocity is at full scale.
      '{16'h4000, 24'd0, 1'b0, 24'd0, 16'hFFFF, 16'hFFFF, 1'b1, 16'sd0},
      '{16'h4000, 24'hFFFFFF, 1'b0, 24'd0, 16'h1234, 16'h8000, 1'b0, 16'sd0},
      '{16'h4000, 24'd5000, 1'b1, 24'hFFFFFF, 16'hFFFF, 16'h0000, 1'b1, 16'sd0},
      '{16'h0000, 24'd1, 1'b0, 24'd0, 16'h0000, 16'h0000, 1'b0, 16'sd0},
      '{16'hFFFF, 24'd2000, 1'b0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'sd0},
      '{16'hFFFF, 24'd2000, 1'b1, 24'd0, 16'hFFFF, 16'hFFFF, 1'b0, 16'sd0},
      '{16'h4000, 24'd100, 1'b1, 24'd1, 16'h0000, 16'hFFFF, 1'b0, 16'sd0},
      '{16'h8000, 24'd65536, 1'b0, 24'd0, 16'hFFFF, 16'h0000, 1'b0, 16'sd0},
      '{16'h0001, 24'd30000, 1'b1, 24'd3000, 16'h5555, 16'hAAAA, 1'b0, 16'sd0},
      '{16'hAAAA, 24'd12, 1'b0, 24'hAAAAAA, 16'hAAAA, 16'h5555, 1'b0, 16'sd0},
      '{16'h5555, 24'h555555, 1'b1, 24'h000555, 16'h8000, 16'h7FFF, 1'b0, 16'sd0},
      '{16'hC000, 24'd400, 1'b0, 24'd0, 16'h0001, 16'h0001, 1'b0, 16'sd0},
      '{16'h2000, 24'd800, 1'b1, 24'd200, 16'hFFFF, 16'hFFFF, 1'b0, 16'sd0},
      '{16'hFFFF, 24'd1500, 1'b0, 24'd0, 16'h0000, 16'hFFFF, 1'b0, 16'sd0},
      '{16'h7FFF, 24'd8000, 1'b1, 24'd6000, 16'hFFFF, 16'h0000, 1'b0, 16'sd0},
      '{16'hFFFF, 24'd2500, 1'b0, 24'd0, 16'h3C3C, 16'hC3C3, 1'b0, 16'sd0}
    };
    phase_steps = '{31'h7FFFFFFF, 31'd0, 31'd1, 31'h0123_4567, 31'h2AAA_AAAA, 31'd91_000_000};
    velocities  = '{16'd0, 16'hFFFF, 16'h8000, 16'd1, 16'hFFFF, 16'h5A5A};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 18; i++) begin
      if (i == 2) begin
        drain();
        write_reg(CFG_PHASE_STEP, 31'h1234_5678);
        write_reg(CFG_VELOCITY, 31'hFFFF);
      end
      send_request(table_rows[i]);
    end

    // Random part: six settings of 300 requests each, the last one without idling.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CFG_PHASE_STEP, phase_steps[ph]);
      write_reg(CFG_VELOCITY, {15'd0, velocities[ph]});
      if (ph == 5) calm = 1'b1;
      for (int n = 0; n < 300; n++) begin
        if (ph == 1 && n == 20) hold_request = 1'b1;
        send_request(random_request());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
